FILE: sv/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

   // Fixed field and register widths
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned ADDR_W     = 64;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned PLEN_W     = 5;
   localparam int unsigned CARE_W     = 16;
   localparam int unsigned PAT_BITS   = 128;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CARE_MASK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDR    = 3'd4;

   // Register reset values
   localparam logic [CARE_W-1:0] CARE_MASK_RESET   = 16'hFFFF;
   localparam logic [PLEN_W-1:0] PATTERN_LEN_RESET = 5'd1;

   // Outcome of one byte in the matcher
   typedef struct packed {
      logic               emit;
      logic               found;
      logic [COUNT_W-1:0] offset;
   } wbps_hit_type;

endpackage : wbps_pkg

`default_nettype wire

FILE: sv/wbps_req_if.sv
`default_nettype none

interface wbps_req_if
   import wbps_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface : wbps_req_if

`default_nettype wire

FILE: sv/wbps_rsp_if.sv
`default_nettype none

interface wbps_rsp_if
   import wbps_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              found;
   logic [ADDR_W-1:0] match_address;

   modport source (output valid, output found, output match_address, input ready);
   modport sink   (input valid, input found, input match_address, output ready);
endinterface : wbps_rsp_if

`default_nettype wire

FILE: sv/wbps_match.sv
`default_nettype none

module wbps_match
   import wbps_pkg::*;
#(
   parameter int unsigned MAX_PATTERN = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [BYTE_W-1:0]   data_byte,
   input  wire logic                last_byte,
   input  wire logic [PAT_BITS-1:0] pattern,
   input  wire logic [CARE_W-1:0]   care_mask,
   input  wire logic [PLEN_W-1:0]   pattern_length,
   output wbps_hit_type             hit
);

   localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [BYTE_W-1:0]  window_ff [MAX_PATTERN];
   logic [BYTE_W-1:0]  window_in [MAX_PATTERN];
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] count_next;
   logic               done_ff;
   logic               done_in;
   logic [LEN_W-1:0]   eff_len;
   logic [IDX_W-1:0]   tap_idx [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] tap_used;
   logic [MAX_PATTERN-1:0] tap_miss;
   logic               is_hit;

   // Clamp the length into 1..MAX_PATTERN
   always_comb begin
      if (pattern_length == '0) begin
         eff_len = LEN_W'(1);
      end else if (pattern_length > PLEN_W'(MAX_PATTERN)) begin
         eff_len = LEN_W'(MAX_PATTERN);
      end else begin
         eff_len = pattern_length[LEN_W-1:0];
      end
   end

   // Shifted window: newest byte at position zero
   always_comb begin
      window_in[0] = data_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   assign count_next = (count_ff == '1) ? count_ff : count_ff + COUNT_W'(1);

   // Pattern byte k lines up with the byte received eff_len-1-k steps ago
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         tap_used[k] = (LEN_W'(k) < eff_len) && care_mask[k];
         tap_idx[k]  = tap_used[k] ? IDX_W'(eff_len - LEN_W'(k) - LEN_W'(1)) : '0;
         tap_miss[k] = tap_used[k] &&
                       (window_in[tap_idx[k]] != pattern[BYTE_W*k +: BYTE_W]);
      end
   end

   assign is_hit = (count_next >= COUNT_W'(eff_len)) && (tap_miss == '0);

   assign hit.emit   = step && !done_ff && (is_hit || last_byte);
   assign hit.found  = is_hit;
   assign hit.offset = count_next - COUNT_W'(eff_len);

   always_comb begin
      count_in = count_ff;
      done_in  = done_ff;
      if (step) begin
         if (last_byte) begin
            count_in = '0;
            done_in  = 1'b0;
         end else if (!done_ff) begin
            count_in = count_next;
            done_in  = is_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // Window entries are only compared once enough bytes of this image have arrived
   always_ff @(posedge clock) begin
      if (step && !done_ff) begin
         window_ff <= window_in;
      end
   end

`ifndef SYNTHESIS
   a_no_emit_after_match: assert property (@(posedge clock) disable iff (reset)
      done_ff && step && !last_byte |-> !hit.emit)
      else $error("result emitted after a match in the same image");

   a_rearm_on_last: assert property (@(posedge clock) disable iff (reset)
      step && last_byte |=> (count_ff == '0) && !done_ff)
      else $error("matcher not re-armed after last byte");

   a_found_needs_bytes: assert property (@(posedge clock) disable iff (reset)
      hit.emit && hit.found |-> count_next >= COUNT_W'(eff_len))
      else $error("match reported before pattern length bytes arrived");
`endif

endmodule : wbps_match

`default_nettype wire

FILE: sv/wildcard_byte_pattern_scan_core.sv
`default_nettype none

// Wildcard byte pattern scanner. Bytes of one image arrive on req_bus, one beat per byte,
// the final byte flagged by last_byte. The block compares a window of the most recent bytes
// against a pattern of up to MAX_PATTERN bytes, each byte either compared or treated as a
// wildcard by care_mask, and returns at most one rsp_bus beat per image: found with
// base_address plus the start offset of the first match, or found clear with a zero address
// when the image ends unmatched. Bytes after a match are dropped until the last byte re-arms
// the scanner. The block takes one byte per clock; the full window compare runs in the cycle
// the byte is accepted, and a result passes an offset stage, then the address adder into the
// output register. Input stalls only while both the offset stage and the output register hold
// an untaken result. Write the registers over the csr_ port only while no image is in flight.

module wildcard_byte_pattern_scan_core
   import wbps_pkg::*;
#(
   parameter int unsigned MAX_PATTERN = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   wbps_req_if.sink                   req_bus,
   wbps_rsp_if.source                 rsp_bus
);

   // Configuration registers
   logic [ADDR_W-1:0] pattern_low_ff;
   logic [ADDR_W-1:0] pattern_high_ff;
   logic [CARE_W-1:0] care_mask_ff;
   logic [PLEN_W-1:0] pattern_len_ff;
   logic [ADDR_W-1:0] base_addr_ff;

   // Offset stage and output register
   logic               stage_valid_ff;
   logic               stage_valid_in;
   logic               stage_found_ff;
   logic [COUNT_W-1:0] stage_offset_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic               out_found_ff;
   logic [ADDR_W-1:0]  out_addr_ff;

   logic         req_fire;
   logic         stage_advance;
   wbps_hit_type hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_mask_ff    <= CARE_MASK_RESET;
         pattern_len_ff  <= PATTERN_LEN_RESET;
         base_addr_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_ff  <= csr_write_data;
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_write_data;
            CSR_CARE_MASK:    care_mask_ff    <= csr_write_data[CARE_W-1:0];
            CSR_PATTERN_LEN:  pattern_len_ff  <= csr_write_data[PLEN_W-1:0];
            CSR_BASE_ADDR:    base_addr_ff    <= csr_write_data;
            default: ;        // unknown index: drop the write
         endcase
      end
   end

   // Advance the offset stage when the output register is free or being drained
   assign stage_advance = stage_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !stage_valid_ff || stage_advance;
   assign req_fire      = req_bus.valid && req_bus.ready;

   wbps_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_match (
      .clock          (clock),
      .reset          (reset),
      .step           (req_fire),
      .data_byte      (req_bus.data_byte),
      .last_byte      (req_bus.last_byte),
      .pattern        ({pattern_high_ff, pattern_low_ff}),
      .care_mask      (care_mask_ff),
      .pattern_length (pattern_len_ff),
      .hit            (hit)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_fire && hit.emit) begin
         stage_valid_in = 1'b1;
      end else if (stage_advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (stage_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Hold the offset of a result beat until the output register takes it
   always_ff @(posedge clock) begin
      if (req_fire && hit.emit) begin
         stage_found_ff  <= hit.found;
         stage_offset_ff <= hit.offset;
      end
   end

   // Add the base; an unmatched image reports a zero address
   always_ff @(posedge clock) begin
      if (stage_advance) begin
         out_found_ff <= stage_found_ff;
         out_addr_ff  <= stage_found_ff ?
                         base_addr_ff + {{(ADDR_W-COUNT_W){1'b0}}, stage_offset_ff} : '0;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.found         = out_found_ff;
   assign rsp_bus.match_address = out_addr_ff;

`ifndef SYNTHESIS
   a_unfound_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_found_ff |-> out_addr_ff == '0)
      else $error("unmatched result carries a non-zero address");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> stage_valid_ff && out_valid_ff && !rsp_bus.ready)
      else $error("input stalled without a full pipeline");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_advance |=> stage_valid_ff && $stable(stage_offset_ff))
      else $error("offset stage lost a beat");

   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      stage_advance |=> out_valid_ff)
      else $error("output register missed a beat");
`endif

endmodule : wildcard_byte_pattern_scan_core

`default_nettype wire
